// ----- sv/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window minimum
// Data and window dimensions, register map and the sweep token that walks
// along the row of window cells.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int WINDOW_MAX = 64;

  // Entry index, fill count and window size widths.
  localparam int IDX_W  = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SIZE_W = 7;
  // Width used when counts and the window size are compared.
  localparam int KW     = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_WINDOW_SIZE = PADDR_W'(0);
  localparam logic [SIZE_W-1:0]  WINDOW_SIZE_RST  = SIZE_W'(1);

  // Largest signed value: the neutral start of a running minimum.
  localparam logic signed [DATA_WIDTH-1:0] DATA_POS_MAX =
    {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // Running minimum handed from one window cell to the next.
  typedef struct packed {
    logic                         valid;
    logic signed [DATA_WIDTH-1:0] min_val;
  } tok_t;

endpackage

`default_nettype wire

// ----- sv/swm_if.sv -----
// ----------------------------------------------------------------------------
// swm_if: stream channels of the sliding window minimum
// Sample channel into the block and result channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_sample_if import swm_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;
  logic                         start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_result_if import swm_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] window_min;

  modport source (output valid, output window_min, input ready);
  modport sink   (input valid, input window_min, output ready);
endinterface

`default_nettype wire

// ----- sv/sliding_window_minimum.sv -----
// ----------------------------------------------------------------------------
// sliding_window_minimum: minimum over the most recent samples of a stream
// Circular window held in a row of cells, with a running minimum swept
// along the row for every result.
// ----------------------------------------------------------------------------
// A sample that only fills the window gives no result and leaves the block
// ready for the next sample. Every sample that gives a result occupies
// the block while the running minimum walks one cell per cycle down the
// full row of WINDOW_MAX window cells, whatever the programmed window
// size, and is then placed in the output
// register. The output register lets the next sample be taken while a
// result still waits for its transfer; a minimum that finds the output
// register still occupied waits in a one-entry hold register, and no sample
// is taken until it has moved on. A start request empties the window before
// its own sample is stored. A window size of zero acts as one and one above
// WINDOW_MAX as WINDOW_MAX; the size should be changed only between
// sequences, followed by a start.
`default_nettype none

module sliding_window_minimum import swm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  swm_sample_if.sink              sample_ch,
  swm_result_if.source            result_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [SIZE_W-1:0] window_size;
  logic [KW-1:0]     k_eff;

  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [IDX_W-1:0] oldest_position, oldest_position_next;
  logic [CNT_W-1:0] fc_base;
  logic [IDX_W-1:0] op_base, op_wrap;
  logic [KW-1:0]    op_inc;
  logic [IDX_W-1:0] wr_idx;
  logic             produce;

  logic accept;
  logic launch;
  logic out_valid;
  logic out_free;
  logic out_load;
  logic signed [DATA_WIDTH-1:0] out_data;
  logic signed [DATA_WIDTH-1:0] hold_data;

  tok_t chain [WINDOW_MAX+1];

  swm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  always_comb begin
    k_eff = KW'(window_size);
    if (window_size == '0) begin
      k_eff = KW'(1);
    end else if (KW'(window_size) > KW'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end
  end

  assign sample_ch.ready = (state == ST_IDLE);
  assign accept          = sample_ch.valid && sample_ch.ready;

  // Write position and window bookkeeping for the sample on offer.
  always_comb begin
    fc_base              = sample_ch.start_req ? '0 : fill_count;
    op_base              = sample_ch.start_req ? '0 : oldest_position;
    op_wrap              = op_base;
    op_inc               = '0;
    wr_idx               = '0;
    produce              = 1'b0;
    fill_count_next      = fc_base;
    oldest_position_next = op_base;
    if (KW'(fc_base) < k_eff) begin
      wr_idx          = fc_base[IDX_W-1:0];
      fill_count_next = fc_base + CNT_W'(1);
      produce         = (KW'(fill_count_next) == k_eff);
      if (produce) begin
        oldest_position_next = '0;
      end
    end else begin
      // Window is full: overwrite the oldest entry and step past it.
      if (KW'(op_base) >= k_eff) begin
        op_wrap = '0;
      end
      wr_idx  = op_wrap;
      op_inc  = KW'(op_wrap) + KW'(1);
      produce = 1'b1;
      oldest_position_next = (op_inc >= k_eff) ? '0 : op_inc[IDX_W-1:0];
    end
  end

  assign chain[0] = {launch, DATA_POS_MAX};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (accept && (wr_idx == IDX_W'(i))),
      .wr_data   (sample_ch.sample),
      .in_window (KW'(i) < k_eff),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1])
    );
  end

  assign out_free = !out_valid || result_ch.ready;

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && produce) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (chain[WINDOW_MAX].valid) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      fill_count      <= '0;
      oldest_position <= '0;
      launch          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept && produce;
      if (accept) begin
        fill_count      <= fill_count_next;
        oldest_position <= oldest_position_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SWEEP) && chain[WINDOW_MAX].valid) begin
      hold_data <= chain[WINDOW_MAX].min_val;
    end
    if (out_load) begin
      out_data <= (state == ST_SWEEP) ? chain[WINDOW_MAX].min_val : hold_data;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.window_min = out_data;

endmodule

`default_nettype wire

// ----- sv/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell: one window entry
// Holds one sample of the window and folds it into the running minimum that
// passes through on its way along the row.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell import swm_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic signed [DATA_WIDTH-1:0] wr_data,
  input  wire logic                         in_window,
  input  wire tok_t                         tok_in,
  output tok_t                              tok_out
);

  logic signed [DATA_WIDTH-1:0] entry;
  logic signed [DATA_WIDTH-1:0] min_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_data;
    end
  end

  // Entries at or beyond the window size are passed over.
  always_comb begin
    min_next = tok_in.min_val;
    if (in_window && (entry < tok_in.min_val)) begin
      min_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.min_val <= min_next;
  end

endmodule

`default_nettype wire

// ----- sv/swm_cfg.sv -----
// ----------------------------------------------------------------------------
// swm_cfg: configuration registers
// APB-style register file holding the window size.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cfg import swm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [SIZE_W-1:0]  window_size
);

  logic wr_access;

  assign pready    = 1'b1;
  assign wr_access = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
    end else if (wr_access && (paddr == ADDR_WINDOW_SIZE)) begin
      window_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_WINDOW_SIZE) begin
      prdata = PDATA_W'(window_size);
    end
  end

endmodule

`default_nettype wire

// ----- bench/sliding_window_minimum_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimum_tb: self-checking bench for the sliding window minimum
// Drives sample streams under several window sizes set over the APB port, keeps
// its own copy of the window to work out every minimum, and compares each
// result transfer with the oldest outstanding minimum.
// ----------------------------------------------------------------------------

module sliding_window_minimum_tb;
  import swm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  // Settling time after the last result, ahead of a register write or the end of the run.
  localparam int SETTLE_CYCLES  = 2 * (WINDOW_MAX + 2);

  localparam logic signed [DATA_WIDTH-1:0] DATA_NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  swm_sample_if sample_ch ();
  swm_result_if result_ch ();

  sliding_window_minimum i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Own copy of the window state and the programmed size.
  logic signed [DATA_WIDTH-1:0] win_vals [WINDOW_MAX];
  int unsigned                  fill_level;
  int unsigned                  oldest_idx;
  logic [SIZE_W-1:0]            cfg_window_size;

  logic signed [DATA_WIDTH-1:0] pending_mins [$];
  int                           err_count = 0;
  bit                           no_idle = 1'b0;
  int                           rx_left = 0;
  bit                           rx_stall = 1'b0;
  int                           quiet_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int unsigned active_size();
    int unsigned k;
    k = cfg_window_size;
    if (k == 0) k = 1;
    if (k > WINDOW_MAX) k = WINDOW_MAX;
    return k;
  endfunction

  // Takes one sample into the window copy; returns 1 when a minimum is due.
  function automatic bit step_window(input logic signed [DATA_WIDTH-1:0] value,
                                     input bit first,
                                     output logic signed [DATA_WIDTH-1:0] wmin);
    int unsigned k;
    k = active_size();
    wmin = '0;
    if (first) begin
      fill_level = 0;
      oldest_idx = 0;
    end
    if (fill_level < k) begin
      win_vals[fill_level % WINDOW_MAX] = value;
      fill_level++;
      if (fill_level < k) return 1'b0;
      oldest_idx = 0;
    end else begin
      if (oldest_idx >= k) oldest_idx = 0;
      win_vals[oldest_idx % WINDOW_MAX] = value;
      oldest_idx++;
      if (oldest_idx >= k) oldest_idx = 0;
    end
    wmin = win_vals[0];
    for (int i = 1; i < k; i++) begin
      if (win_vals[i] < wmin) wmin = win_vals[i];
    end
    return 1'b1;
  endfunction

  // Sends one sample, holding valid across back-to-back transfers.
  task automatic send_sample(input logic signed [DATA_WIDTH-1:0] value, input bit first);
    logic signed [DATA_WIDTH-1:0] wmin;
    int                           gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_ch.valid     <= 1'b1;
    sample_ch.sample    <= value;
    sample_ch.start_req <= first;
    do @(posedge clk); while (!sample_ch.ready);
    if (step_window(value, first, wmin)) pending_mins.push_back(wmin);
  endtask

  task automatic stop_samples();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
  endtask

  // Register writes only happen with the block drained and idle.
  task automatic set_window_size(input int unsigned size);
    stop_samples();
    while (pending_mins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW_SIZE;
    pwdata  <= PDATA_W'(size);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_window_size = SIZE_W'(size);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return DATA_NEG_MIN;
      1:       return DATA_POS_MAX;
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3, 4:    return DATA_WIDTH'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_size();
    send_sample(DATA_NEG_MIN, 1'b1);
    send_sample(DATA_POS_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(1, 1'b0);
  endtask

  task automatic test_small_window();
    set_window_size(3);
    send_sample(DATA_POS_MAX, 1'b1);
    send_sample(DATA_NEG_MIN, 1'b0);
    send_sample(5, 1'b0);
    send_sample(DATA_POS_MAX, 1'b0);
    send_sample(DATA_POS_MAX, 1'b0);
    send_sample(DATA_POS_MAX, 1'b0);
    // A start before the window has filled abandons that sequence.
    send_sample(-7, 1'b1);
    send_sample(3, 1'b0);
    send_sample(4, 1'b1);
    send_sample(4, 1'b0);
    send_sample(4, 1'b0);
  endtask

  task automatic test_resize_mid_sequence();
    // Growing the window resumes filling; shrinking treats it as full.
    set_window_size(5);
    send_sample(-2, 1'b0);
    send_sample(9, 1'b0);
    send_sample(DATA_NEG_MIN, 1'b0);
    set_window_size(2);
    send_sample(8, 1'b0);
    send_sample(DATA_POS_MAX, 1'b0);
    send_sample(-1, 1'b0);
  endtask

  task automatic test_random_phase(input int unsigned size, input int n_items,
                                   input bit start_first);
    int          sent;
    int          seq_len;
    int unsigned k;
    bit          first;
    bit          opening;
    set_window_size(size);
    k       = active_size();
    sent    = 0;
    opening = 1'b1;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) seq_len = $urandom_range(1, k);
      else seq_len = k + $urandom_range(0, k + 16);
      for (int i = 0; i < seq_len && sent < n_items; i++) begin
        first = (i == 0) && (!opening || start_first);
        if ($urandom_range(0, 49) == 0) first = 1'b1;
        send_sample(pick_sample(), first);
        sent++;
      end
      opening = 1'b0;
    end
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.sample    = '0;
    sample_ch.start_req = 1'b0;
    result_ch.ready     = 1'b0;
    cfg_window_size     = WINDOW_SIZE_RST;
    fill_level          = 0;
    oldest_idx          = 0;
    foreach (win_vals[i]) win_vals[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_small_window();
    test_resize_mid_sequence();
    test_random_phase(1, 100, 1'b1);
    test_random_phase(WINDOW_MAX, 250, 1'b1);
    test_random_phase(2, 120, 1'b0);
    test_random_phase(5, 100, 1'b1);
    test_random_phase(127, 200, 1'b1);
    test_random_phase(9, 120, 1'b0);
    test_random_phase(30, 120, 1'b0);
    test_random_phase($urandom_range(1, WINDOW_MAX), 150, 1'b1);
    no_idle = 1'b1;
    test_random_phase($urandom_range(1, 16), 150, 1'b1);
    stop_samples();

    while (pending_mins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result sink: random stall bursts between runs of readiness, none once no_idle is set.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        rx_stall = 1'b1;
        rx_left  = $urandom_range(1, 10);
      end else begin
        rx_stall = 1'b0;
        rx_left  = $urandom_range(1, 30);
      end
    end
    rx_left--;
    result_ch.ready <= !rx_stall;
  end

  always @(posedge clk) begin
    logic signed [DATA_WIDTH-1:0] want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_mins.size() == 0) begin
        report_mismatch($sformatf("unexpected result window_min=%0d", result_ch.window_min));
      end else begin
        want = pending_mins.pop_front();
        if (result_ch.window_min !== want)
          report_mismatch($sformatf("window_min got %0d, want %0d",
                                    result_ch.window_min, want));
      end
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
sv/swm_pkg.sv
sv/swm_if.sv
sv/swm_cell.sv
sv/swm_cfg.sv
sv/sliding_window_minimum.sv
bench/sliding_window_minimum_tb.sv
